// ===== rtl/core/wht_pkg.sv =====
// Package for the WPA2 handshake tracker: constants, result codes, types.
// No dependencies.
`default_nettype none
package wht_pkg;
    localparam int ENTRIES_DEF    = 8;
    localparam int SSID_BYTES_DEF = 32;
    localparam int MAC_W          = 48;
    localparam int WORD_W         = 64;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SSID_W0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SSID_W1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SSID_W2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SSID_W3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SSID_LEN = 3'd4;

    typedef enum logic [3:0] {
        RC_NEW       = 4'd0,
        RC_MSG2      = 4'd1,
        RC_MSG3      = 4'd2,
        RC_DONE      = 4'd3,
        RC_IGNORED   = 4'd4,
        RC_RESTART   = 4'd5,
        RC_FULL      = 4'd6,
        RC_BCN_TAKEN = 4'd7,
        RC_BCN_IGN   = 4'd8
    } rcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NAME,
        ST_DECIDE,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       action;
        logic [WORD_W-1:0] data_w0;
        logic [WORD_W-1:0] data_w1;
        logic [WORD_W-1:0] data_w2;
        logic [WORD_W-1:0] data_w3;
        logic [5:0] ssid_length;
        logic [WORD_W-1:0] replay_counter;
        logic [MAC_W-1:0]  source_mac;
        logic [MAC_W-1:0]  dest_mac;
    } item_t;

    typedef struct packed {
        logic       key_ready;
        logic [3:0] result_code;
        logic [MAC_W-1:0]  first_sender_mac;
        logic [MAC_W-1:0]  first_receiver_mac;
        logic [WORD_W-1:0] anonce_w0;
        logic [WORD_W-1:0] anonce_w1;
        logic [WORD_W-1:0] anonce_w2;
        logic [WORD_W-1:0] anonce_w3;
        logic [WORD_W-1:0] snonce_w0;
        logic [WORD_W-1:0] snonce_w1;
        logic [WORD_W-1:0] snonce_w2;
        logic [WORD_W-1:0] snonce_w3;
    } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/wht_if.sv =====
// Valid/ready channel interfaces for item and result transfers.
// Depends on wht_pkg.
`default_nettype none
interface wht_item_if;
    logic           valid;
    logic           ready;
    wht_pkg::item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wht_result_if;
    logic             valid;
    logic             ready;
    wht_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wht_cmp_unit.sv =====
// Shared compare unit: one 64-bit equality per cycle plus the 8-byte masked
// name compare used for beacons. Depends on wht_pkg.
`default_nettype none
module wht_cmp_unit
(
    input  wire logic [wht_pkg::WORD_W-1:0] a,
    input  wire logic [wht_pkg::WORD_W-1:0] b,
    input  wire logic [7:0]                 byte_mask,
    output logic                            eq
);
    import wht_pkg::*;

    logic [WORD_W-1:0] diff;
    always_comb
    begin
        diff = a ^ b;
        eq = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (byte_mask[i] && (diff[8*i +: 8] != 8'd0))
                eq = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/wpa_handshake_tracker_top.sv =====
// Top level of the WPA2 handshake tracker: sequencer, entry table, nonce memories.
// Depends on wht_pkg, wht_if and wht_cmp_unit.
// Sequence: an EAPOL item scans every entry (four scan steps per used entry, one
// per free entry), then the chosen row is read and decided; a beacon takes four name steps.
// Flow: one item at a time; the next is taken the cycle after the result transfer.
// Reset: table valid bits, beacon latch and sequencer clear at once; no clearing pass.
`default_nettype none
module wpa_handshake_tracker_top
#(
    parameter int ENTRIES    = wht_pkg::ENTRIES_DEF,
    parameter int SSID_BYTES = wht_pkg::SSID_BYTES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    wht_item_if.sink                           item_in,
    wht_result_if.source                       result_out,
    input  wire logic                          cfg_we,
    input  wire logic [wht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wht_pkg::WORD_W-1:0]    cfg_data
);
    import wht_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // configuration
    logic [WORD_W-1:0] tssid_reg [4];
    logic [5:0]        tlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                tssid_reg[i] <= '0;
            tlen_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SSID_W0:  tssid_reg[0] <= cfg_data;
                REG_SSID_W1:  tssid_reg[1] <= cfg_data;
                REG_SSID_W2:  tssid_reg[2] <= cfg_data;
                REG_SSID_W3:  tssid_reg[3] <= cfg_data;
                REG_SSID_LEN: tlen_reg <= cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    // entry table
    logic [ENTRIES-1:0] valid_reg;
    logic [1:0]         stage_mem [ENTRIES];
    logic [WORD_W-1:0]  cnt_mem   [ENTRIES];
    logic [MAC_W-1:0]   snd_mem   [ENTRIES];
    logic [MAC_W-1:0]   rcv_mem   [ENTRIES];
    logic [WORD_W-1:0]  anonce_mem [4*ENTRIES];
    logic [WORD_W-1:0]  snonce_mem [4*ENTRIES];

    logic              beacon_seen_reg;
    logic [MAC_W-1:0]  beacon_mac_reg;

    state_t            state_reg, state_next;
    item_t             item_reg;
    logic [EW-1:0]     idx_reg, idx_next;
    logic [1:0]        sub_reg, sub_next;   // compare step within an entry
    logic              fwd_reg, fwd_next;
    logic              bwd_reg, bwd_next;
    logic              found_reg, found_next;
    logic [EW-1:0]     found_idx_reg, found_idx_next;
    logic              free_ok_reg, free_ok_next;
    logic [EW-1:0]     free_idx_reg, free_idx_next;
    logic              name_eq_reg, name_eq_next;
    logic              res_valid_reg;
    result_t           res_reg;

    // registered row read of the chosen entry
    logic [1:0]        rd_stage_reg;
    logic [WORD_W-1:0] rd_cnt_reg;
    logic [MAC_W-1:0]  rd_snd_reg, rd_rcv_reg;
    logic [WORD_W-1:0] rd_an_reg [4];
    logic [WORD_W-1:0] rd_sn_reg [4];

    // shared compare operands
    logic [WORD_W-1:0] ca, cb;
    logic [7:0]        cmask;
    logic              ceq;

    wht_cmp_unit u_cmp (.a(ca), .b(cb), .byte_mask(cmask), .eq(ceq));

    logic [5:0] lb, lt;
    assign lb = (item_reg.ssid_length > 6'(SSID_BYTES)) ? 6'(SSID_BYTES) : item_reg.ssid_length;
    assign lt = (tlen_reg > 6'(SSID_BYTES)) ? 6'(SSID_BYTES) : tlen_reg;

    logic [WORD_W-1:0] dword;
    always_comb
    begin
        case (sub_reg)
            2'd0:    dword = item_reg.data_w0;
            2'd1:    dword = item_reg.data_w1;
            2'd2:    dword = item_reg.data_w2;
            default: dword = item_reg.data_w3;
        endcase
    end

    logic [5:0] word_base;
    assign word_base = {sub_reg, 3'b000, 1'b0} >> 1;
    always_comb
    begin
        ca = '0;
        cb = '0;
        cmask = 8'hFF;
        if (state_reg == ST_NAME)
        begin
            ca = tssid_reg[sub_reg];
            cb = dword;
            for (int i = 0; i < 8; i++)
                cmask[i] = (word_base + 6'(i)) < lt;
        end
        else
        begin
            case (sub_reg)
                2'd0:
                begin
                    ca = {16'd0, snd_mem[idx_reg]};
                    cb = {16'd0, item_reg.source_mac};
                end
                2'd1:
                begin
                    ca = {16'd0, rcv_mem[idx_reg]};
                    cb = {16'd0, item_reg.dest_mac};
                end
                2'd2:
                begin
                    ca = {16'd0, snd_mem[idx_reg]};
                    cb = {16'd0, item_reg.dest_mac};
                end
                default:
                begin
                    ca = {16'd0, rcv_mem[idx_reg]};
                    cb = {16'd0, item_reg.source_mac};
                end
            endcase
        end
    end

    // decision on the read row
    logic               same_cnt, next_cnt, same_nonce;
    logic               is_fwd, is_bwd;
    logic [EW-1:0]      sel;
    assign sel       = found_reg ? found_idx_reg : free_idx_reg;
    assign is_fwd    = (rd_snd_reg == item_reg.source_mac) && (rd_rcv_reg == item_reg.dest_mac);
    assign is_bwd    = (rd_snd_reg == item_reg.dest_mac) && (rd_rcv_reg == item_reg.source_mac);
    assign same_cnt  = rd_cnt_reg == item_reg.replay_counter;
    assign next_cnt  = (rd_cnt_reg + 64'd1) == item_reg.replay_counter;
    assign same_nonce = (rd_an_reg[0] == item_reg.data_w0) && (rd_an_reg[1] == item_reg.data_w1)
                     && (rd_an_reg[2] == item_reg.data_w2) && (rd_an_reg[3] == item_reg.data_w3);

    typedef enum logic [1:0] { WR_NONE, WR_START, WR_SNONCE, WR_STAGE } wr_t;
    wr_t        wr_kind;
    logic [1:0] wr_stage;
    rcode_t     dcode;

    always_comb
    begin
        wr_kind  = WR_NONE;
        wr_stage = 2'd0;
        dcode    = RC_IGNORED;
        if (!found_reg)
        begin
            wr_kind = WR_START;
            dcode   = RC_NEW;
        end
        else if (same_cnt)
        begin
            if (rd_stage_reg == 2'd0 && is_bwd)
            begin
                wr_kind  = WR_SNONCE;
                wr_stage = 2'd1;
                dcode    = RC_MSG2;
            end
        end
        else if (next_cnt && rd_stage_reg == 2'd1 && is_fwd && same_nonce)
        begin
            wr_kind  = WR_STAGE;
            wr_stage = 2'd2;
            dcode    = RC_MSG3;
        end
        else if (next_cnt && rd_stage_reg == 2'd2 && is_bwd)
        begin
            wr_kind  = WR_STAGE;
            wr_stage = 2'd3;
            dcode    = RC_DONE;
        end
        else
        begin
            wr_kind = WR_START;
            dcode   = RC_RESTART;
        end
    end

    // beacon match and the all-zero results (beacon, table full)
    logic    bcn_hit;
    result_t short_res;
    assign bcn_hit = !beacon_seen_reg && (lb == lt) && name_eq_reg && ceq;
    always_comb
    begin
        short_res = '0;
        if (state_reg == ST_NAME)
            short_res.result_code = bcn_hit ? RC_BCN_TAKEN : RC_BCN_IGN;
        else
            short_res.result_code = RC_FULL;
    end

    logic take;
    assign take = item_in.valid && item_in.ready;
    assign item_in.ready = (state_reg == ST_IDLE);
    assign result_out.valid = res_valid_reg;
    assign result_out.payload = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sub_next       = sub_reg;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        name_eq_next   = name_eq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    idx_next     = '0;
                    sub_next     = 2'd0;
                    fwd_next     = 1'b1;
                    bwd_next     = 1'b1;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    name_eq_next = 1'b1;
                    state_next   = item_in.payload.action ? ST_NAME : ST_SCAN;
                end
            end
            ST_NAME:
            begin
                if (!ceq)
                    name_eq_next = 1'b0;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                    state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    if (!free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    sub_next = 2'd3;
                end
                else
                begin
                    if ((sub_reg == 2'd0 || sub_reg == 2'd1) && !ceq)
                        fwd_next = 1'b0;
                    if ((sub_reg == 2'd2 || sub_reg == 2'd3) && !ceq)
                        bwd_next = 1'b0;
                    sub_next = sub_reg + 2'd1;
                end
                if (sub_reg == 2'd3 || !valid_reg[idx_reg])
                begin
                    if (valid_reg[idx_reg] && !found_reg &&
                        (fwd_reg || (bwd_reg && ceq)))
                    begin
                        found_next     = 1'b1;
                        found_idx_next = idx_reg;
                    end
                    sub_next = 2'd0;
                    fwd_next = 1'b1;
                    bwd_next = 1'b1;
                    if (32'(idx_reg) == ENTRIES - 1)
                        state_next = ST_READ;
                    else
                        idx_next = idx_reg + EW'(1);
                end
            end
            ST_READ:
            begin
                state_next = (found_reg || free_ok_reg) ? ST_DECIDE : ST_OUT;
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_valid_reg && result_out.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            beacon_seen_reg <= 1'b0;
            beacon_mac_reg  <= '0;
            res_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            sub_reg         <= '0;
            fwd_reg         <= 1'b0;
            bwd_reg         <= 1'b0;
            found_reg       <= 1'b0;
            found_idx_reg   <= '0;
            free_ok_reg     <= 1'b0;
            free_idx_reg    <= '0;
            name_eq_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sub_reg       <= sub_next;
            fwd_reg       <= fwd_next;
            bwd_reg       <= bwd_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            free_ok_reg   <= free_ok_next;
            free_idx_reg  <= free_idx_next;
            name_eq_reg   <= name_eq_next;
            if (result_out.valid && result_out.ready)
                res_valid_reg <= 1'b0;
            if (state_reg == ST_NAME && sub_reg == 2'd3)
            begin
                res_valid_reg <= 1'b1;
                if (bcn_hit)
                begin
                    beacon_seen_reg <= 1'b1;
                    beacon_mac_reg  <= item_reg.source_mac;
                end
            end
            if (state_reg == ST_READ && !(found_reg || free_ok_reg))
                res_valid_reg <= 1'b1;
            if (state_reg == ST_DECIDE)
            begin
                res_valid_reg <= 1'b1;
                if (wr_kind == WR_START)
                    valid_reg[sel] <= 1'b1;
            end
        end
    end

    // payload, tables and result
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in.payload;
        if (state_reg == ST_READ)
        begin
            rd_stage_reg <= stage_mem[sel];
            rd_cnt_reg   <= cnt_mem[sel];
            rd_snd_reg   <= snd_mem[sel];
            rd_rcv_reg   <= rcv_mem[sel];
            for (int w = 0; w < 4; w++)
            begin
                rd_an_reg[w] <= anonce_mem[{sel, 2'(w)}];
                rd_sn_reg[w] <= snonce_mem[{sel, 2'(w)}];
            end
        end
        if ((state_reg == ST_NAME && sub_reg == 2'd3) ||
            (state_reg == ST_READ && !(found_reg || free_ok_reg)))
            res_reg <= short_res;
        if (state_reg == ST_DECIDE)
        begin
            res_reg.result_code <= dcode;
            if (wr_kind == WR_START)
            begin
                stage_mem[sel] <= 2'd0;
                cnt_mem[sel]   <= item_reg.replay_counter;
                snd_mem[sel]   <= item_reg.source_mac;
                rcv_mem[sel]   <= item_reg.dest_mac;
                anonce_mem[{sel, 2'd0}] <= item_reg.data_w0;
                anonce_mem[{sel, 2'd1}] <= item_reg.data_w1;
                anonce_mem[{sel, 2'd2}] <= item_reg.data_w2;
                anonce_mem[{sel, 2'd3}] <= item_reg.data_w3;
                res_reg.key_ready <= 1'b0;
                res_reg.first_sender_mac   <= item_reg.source_mac;
                res_reg.first_receiver_mac <= item_reg.dest_mac;
                res_reg.anonce_w0 <= item_reg.data_w0;
                res_reg.anonce_w1 <= item_reg.data_w1;
                res_reg.anonce_w2 <= item_reg.data_w2;
                res_reg.anonce_w3 <= item_reg.data_w3;
            end
            else
            begin
                res_reg.first_sender_mac   <= rd_snd_reg;
                res_reg.first_receiver_mac <= rd_rcv_reg;
                res_reg.anonce_w0 <= rd_an_reg[0];
                res_reg.anonce_w1 <= rd_an_reg[1];
                res_reg.anonce_w2 <= rd_an_reg[2];
                res_reg.anonce_w3 <= rd_an_reg[3];
                res_reg.key_ready <= beacon_seen_reg && (rd_snd_reg == beacon_mac_reg) &&
                    (((wr_kind == WR_STAGE) && (wr_stage == 2'd3)) ||
                     ((wr_kind == WR_NONE) && (rd_stage_reg == 2'd3)));
            end
            if (wr_kind == WR_SNONCE)
            begin
                stage_mem[sel] <= wr_stage;
                snonce_mem[{sel, 2'd0}] <= item_reg.data_w0;
                snonce_mem[{sel, 2'd1}] <= item_reg.data_w1;
                snonce_mem[{sel, 2'd2}] <= item_reg.data_w2;
                snonce_mem[{sel, 2'd3}] <= item_reg.data_w3;
                res_reg.snonce_w0 <= item_reg.data_w0;
                res_reg.snonce_w1 <= item_reg.data_w1;
                res_reg.snonce_w2 <= item_reg.data_w2;
                res_reg.snonce_w3 <= item_reg.data_w3;
            end
            else
            begin
                res_reg.snonce_w0 <= rd_sn_reg[0];
                res_reg.snonce_w1 <= rd_sn_reg[1];
                res_reg.snonce_w2 <= rd_sn_reg[2];
                res_reg.snonce_w3 <= rd_sn_reg[3];
            end
            if (wr_kind == WR_STAGE)
                stage_mem[sel] <= wr_stage;
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !item_in.ready)
        else $error("item taken while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.ready) |=> (result_out.valid && $stable(res_reg)))
        else $error("result dropped under stall");
    a_beacon_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        beacon_seen_reg |=> (beacon_seen_reg && $stable(beacon_mac_reg)))
        else $error("beacon latch changed");
    a_valid_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (state_reg == ST_OUT))
        else $error("result outside output state");
`endif
endmodule
`default_nettype wire
